FILE: hw/rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// Linear-probe hash table package
// Shared types and codes for the route table core and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package lph_pkg;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_opcode;

    // Result codes
    typedef enum logic [1:0] {
        RES_OK   = 2'd0,
        RES_MISS = 2'd1,
        RES_FULL = 2'd2
    } t_result;

    // Slot status
    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_USED    = 2'd1,
        ST_DELETED = 2'd2
    } t_slot_st;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_RESP
    } t_state;

    // One table entry as held in the slot store
    typedef struct packed {
        t_slot_st    status;
        logic [7:0]  key;
        logic [7:0]  hop;
    } t_slot_entry;

    // Access request from the sequencer to the slot store
    typedef struct packed {
        logic        rd_en;
        logic [7:0]  rd_addr;
        logic        wr_en;
        logic [7:0]  wr_addr;
        t_slot_entry wr_data;
    } t_store_req;

endpackage

`default_nettype wire

FILE: hw/rtl/lph_home_unit.sv
// ----------------------------------------------------------------------------
// Home slot unit
// Reduces a key modulo the slot count. The quotient comes from a multiply by
// the rounded-up reciprocal of the slot count, then one multiply-back and
// subtract gives the remainder. A new key may start while the last finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_home_unit #(
    parameter int TABLE_SLOTS = 40
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [7:0]                       i_key,
    output logic                                  o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0]        o_home
);
    import lph_pkg::*;

    localparam int          SW    = $clog2(TABLE_SLOTS);
    // 16 fraction bits keep the quotient exact for every 8-bit key
    localparam int          MAGIC = (65536 + TABLE_SLOTS - 1) / TABLE_SLOTS;
    localparam logic [15:0] DIV16 = 16'(TABLE_SLOTS);
    localparam logic [23:0] MUL24 = 24'(MAGIC);

    logic [7:0]  r_key;
    logic [7:0]  r_quo;
    logic [7:0]  r_rem;
    logic        r_busy;
    logic        r_done;
    logic [23:0] w_prod;
    logic [15:0] w_back;

    // Reciprocal multiply for the quotient, multiply-back for the remainder
    always_comb begin
        w_prod = {16'd0, i_key} * MUL24;
        w_back = {8'd0, r_quo} * DIV16;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    // Quotient, then remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_quo <= w_prod[23:16];
        end
        if (r_busy) begin
            // quotient times slot count never exceeds the key
            r_rem <= r_key - w_back[7:0];
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem[SW-1:0];

endmodule

`default_nettype wire

FILE: hw/rtl/lph_slot_store.sv
// ----------------------------------------------------------------------------
// Slot store
// Table memory with one write and one registered read port. A valid bit per
// slot, cleared at reset, makes an unwritten slot read back as empty.
// ----------------------------------------------------------------------------
`default_nettype none

module lph_slot_store #(
    parameter int TABLE_SLOTS = 40
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire lph_pkg::t_store_req  i_req,
    output lph_pkg::t_slot_entry      o_rsp
);
    import lph_pkg::*;

    localparam int SW = $clog2(TABLE_SLOTS);

    t_slot_entry              r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0]   r_vld;
    t_slot_entry              r_rd_data;
    logic                     r_rd_vld;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr[SW-1:0]] <= 1'b1;
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[SW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr[SW-1:0]];
            r_rd_vld  <= r_vld[i_req.rd_addr[SW-1:0]];
        end
    end

    // Unwritten slots read as empty
    always_comb begin
        o_rsp.status = r_rd_vld ? r_rd_data.status : ST_EMPTY;
        o_rsp.key    = r_rd_data.key;
        o_rsp.hop    = r_rd_data.hop;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table_core.sv
// Flow: home slot unit, then a probe of P slots, P = slots probed
//   (1 to TABLE_SLOTS); an unused opcode goes straight to the reply.
// Throughput: one request at a time; home slot unit first, then one slot per
//   cycle through the single registered read port. A held result stalls the reply.
// Reset: synchronous; slot valid bits clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// Linear-probe hash table core
// Open-addressing route table: search, insert and delete with linear probing
// and wrap, deleted marks skipped by search and delete and reused by insert,
// full table flagged on insert.
`default_nettype none

module linear_probe_hash_table_core #(
    parameter int TABLE_SLOTS = 40
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_node_key,
    input  wire logic [7:0]  i_next_hop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_found_hop,
    output logic [7:0]       o_slot_index
);
    import lph_pkg::*;

    localparam int SW = $clog2(TABLE_SLOTS);

    t_state       r_state;
    t_state       n_state;
    logic [1:0]   r_op;
    logic [7:0]   r_key;
    logic [7:0]   r_hop;
    logic [SW-1:0] r_ptr;
    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_cnt;
    t_result      r_res_status;
    logic [7:0]   r_res_hop;
    logic [7:0]   r_res_idx;
    logic         r_out_valid;
    t_result      r_out_status;
    logic [7:0]   r_out_hop;
    logic [7:0]   r_out_idx;

    logic          w_accept;
    logic          w_home_start;
    logic          w_home_done;
    logic [SW-1:0] w_home;
    t_store_req    w_req;
    t_slot_entry   w_slot;
    logic          w_out_free;

    // Probe decision
    logic          w_is_ins;
    logic          w_last;
    logic          w_hit_find;
    logic          w_stop_empty;
    logic          w_hit_ins;
    logic          w_term;
    t_result       w_res_status;
    logic [7:0]    w_res_hop;
    logic [7:0]    w_res_idx;
    logic          w_bad_op;

    // Home slot unit
    lph_home_unit #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_home_start),
        .i_key   (i_node_key),
        .o_done  (w_home_done),
        .o_home  (w_home)
    );

    // Slot store
    lph_slot_store #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_slot)
    );

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] s);
        return (s == SW'(TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
    endfunction

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_bad_op   = (i_opcode != OP_SEARCH) && (i_opcode != OP_INSERT)
                        && (i_opcode != OP_DELETE);

    // Decision on the slot read back this cycle
    always_comb begin
        w_is_ins     = (r_op == OP_INSERT);
        w_last       = (r_cnt == SW'(TABLE_SLOTS - 1));
        w_hit_find   = !w_is_ins && (w_slot.status == ST_USED) && (w_slot.key == r_key);
        w_stop_empty = !w_is_ins && (w_slot.status == ST_EMPTY);
        w_hit_ins    = w_is_ins && (w_slot.status != ST_USED);
        w_term       = w_hit_find || w_stop_empty || w_hit_ins || w_last;
        w_res_hop    = 8'd0;
        w_res_idx    = 8'd0;
        if (w_hit_find) begin
            w_res_status = RES_OK;
            w_res_hop    = w_slot.hop;
            w_res_idx    = 8'(r_cur);
        end else if (w_hit_ins) begin
            w_res_status = RES_OK;
            w_res_idx    = 8'(r_cur);
        end else if (w_is_ins) begin
            w_res_status = RES_FULL;
        end else begin
            w_res_status = RES_MISS;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad_op ? S_RESP : S_HOME;
                end
            end
            S_HOME: begin
                if (w_home_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_term) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs and store requests
    always_comb begin
        o_ready         = 1'b0;
        w_home_start    = 1'b0;
        w_req.rd_en     = 1'b0;
        w_req.rd_addr   = 8'(r_ptr);
        w_req.wr_en     = 1'b0;
        w_req.wr_addr   = 8'(r_cur);
        w_req.wr_data.status = ST_USED;
        w_req.wr_data.key    = r_key;
        w_req.wr_data.hop    = r_hop;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                w_home_start = i_valid && !w_bad_op;
            end
            S_HOME: begin
                w_req.rd_en   = w_home_done;
                w_req.rd_addr = 8'(w_home);
            end
            S_PROBE: begin
                w_req.rd_en = !w_term;
                if (w_hit_ins) begin
                    w_req.wr_en = 1'b1;
                end else if (w_hit_find && (r_op == OP_DELETE)) begin
                    // Keep key and neighbour, mark the slot deleted
                    w_req.wr_en          = 1'b1;
                    w_req.wr_data.status = ST_DELETED;
                    w_req.wr_data.hop    = w_slot.hop;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    // State register and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RESP && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture, probe pointers and pending result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= i_opcode;
            r_key        <= i_node_key;
            r_hop        <= i_next_hop;
            r_res_status <= RES_MISS;
            r_res_hop    <= 8'd0;
            r_res_idx    <= 8'd0;
        end
        if (r_state == S_HOME && w_home_done) begin
            r_cur <= w_home;
            r_ptr <= f_next(w_home);
            r_cnt <= '0;
        end
        if (r_state == S_PROBE) begin
            if (w_term) begin
                r_res_status <= w_res_status;
                r_res_hop    <= w_res_hop;
                r_res_idx    <= w_res_idx;
            end else begin
                r_cur <= r_ptr;
                r_ptr <= f_next(r_ptr);
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (r_state == S_RESP && w_out_free) begin
            r_out_status <= r_res_status;
            r_out_hop    <= r_res_hop;
            r_out_idx    <= r_res_idx;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_found_hop  = r_out_hop;
    assign o_slot_index = r_out_idx;

    // Home unit finishes only while the sequencer waits for it
    a_home_done_in_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_home_done |-> (r_state == S_HOME))
        else $error("home unit done outside home phase");

    // Table is written only on the final probe of a request
    a_write_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.wr_en |-> (r_state == S_PROBE) && w_term && !w_req.rd_en)
        else $error("slot write outside a terminating probe");

    // Walk never passes the slot count
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_cnt <= SW'(TABLE_SLOTS - 1)))
        else $error("probe walk exceeded table size");

    // A request keeps the block busy until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("new request taken while one is in flight");

endmodule

`default_nettype wire
